// ===== design/gtm_pkg.sv =====
// Shared types and constants for the Goertzel tone magnitude block.
// Used by the register file, the controller, the datapath and the top level.
`default_nettype none

package gtm_pkg;

   // Default values for the top-level parameters.
   localparam int SAMPLE_WIDTH_DEFAULT   = 16;
   localparam int COEF_FRAC_BITS_DEFAULT = 14;
   localparam int ACC_WIDTH_DEFAULT      = 48;

   // The shared multiplier works on unsigned chunks of this width.
   localparam int CHUNK_WIDTH = 24;

   // Fixed field widths.
   localparam int TWO_COS_WIDTH = 17;
   localparam int TRIG_WIDTH    = 16;
   localparam int MAG_WIDTH     = 48;

   // Configuration port.
   localparam int CSR_ADDR_WIDTH = 4;
   localparam int CSR_DATA_WIDTH = 32;

   // Register indexes (word address within the configuration port).
   localparam logic [1:0] REG_TWO_COS = 2'd0;
   localparam logic [1:0] REG_COS     = 2'd1;
   localparam logic [1:0] REG_SIN     = 2'd2;

   // Register reset values.
   localparam logic [TWO_COS_WIDTH-1:0] TWO_COS_RESET = '0;
   localparam logic [TRIG_WIDTH-1:0]    COS_RESET     = 16'd16384;
   localparam logic [TRIG_WIDTH-1:0]    SIN_RESET     = '0;

   // Datapath operations.
   typedef enum logic [3:0] {
      OP_IDLE,
      OP_LOAD,
      OP_MUL,
      OP_ROUND,
      OP_SUB_D2,
      OP_ADD_X,
      OP_REAL,
      OP_ROOT_INIT,
      OP_ROOT_STEP,
      OP_OUT
   } op_type;

   // Multiplier operand A source.
   typedef enum logic [1:0] {
      A_D1,
      A_D2,
      A_REAL,
      A_IMAG
   } a_sel_type;

   // Multiplier operand B source.
   typedef enum logic [2:0] {
      B_TWO_COS,
      B_COS,
      B_SIN,
      B_REAL,
      B_IMAG
   } b_sel_type;

   // Command from the controller to the datapath.
   typedef struct packed {
      op_type    op;
      a_sel_type a_sel;
      b_sel_type b_sel;
      logic      acc_clr;
   } cmd_type;

endpackage

`default_nettype wire

// ===== design/gtm_csr.sv =====
// Configuration registers behind an APB-style port.
// Depends on gtm_pkg for register indexes, widths and reset values.
`default_nettype none

module gtm_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [gtm_pkg::CSR_ADDR_WIDTH-1:0]   paddr,
   input  wire logic [gtm_pkg::CSR_DATA_WIDTH-1:0]   pwdata,
   output logic      [gtm_pkg::CSR_DATA_WIDTH-1:0]   prdata,
   output logic                                      pready,
   output logic      [gtm_pkg::TWO_COS_WIDTH-1:0]    coeff_two_cos,
   output logic      [gtm_pkg::TRIG_WIDTH-1:0]       cos_term,
   output logic      [gtm_pkg::TRIG_WIDTH-1:0]       sin_term
);

   localparam int DW = gtm_pkg::CSR_DATA_WIDTH;
   localparam int CW = gtm_pkg::TWO_COS_WIDTH;
   localparam int TW = gtm_pkg::TRIG_WIDTH;

   logic [CW-1:0] two_cos_ff;
   logic [TW-1:0] cos_ff;
   logic [TW-1:0] sin_ff;
   logic          wr_en;
   logic [1:0]    reg_idx;

   // A write transfer completes in the access phase.
   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite && pready;
   assign reg_idx = paddr[3:2];

   // Register writes; an unmapped index is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         two_cos_ff <= gtm_pkg::TWO_COS_RESET;
         cos_ff     <= gtm_pkg::COS_RESET;
         sin_ff     <= gtm_pkg::SIN_RESET;
      end else if (wr_en) begin
         case (reg_idx)
            gtm_pkg::REG_TWO_COS: two_cos_ff <= pwdata[CW-1:0];
            gtm_pkg::REG_COS:     cos_ff     <= pwdata[TW-1:0];
            gtm_pkg::REG_SIN:     sin_ff     <= pwdata[TW-1:0];
            default: ;
         endcase
      end
   end

   // Read data, sign-extended to the bus width.
   always_comb begin
      case (reg_idx)
         gtm_pkg::REG_TWO_COS: prdata = {{(DW-CW){two_cos_ff[CW-1]}}, two_cos_ff};
         gtm_pkg::REG_COS:     prdata = {{(DW-TW){cos_ff[TW-1]}}, cos_ff};
         gtm_pkg::REG_SIN:     prdata = {{(DW-TW){sin_ff[TW-1]}}, sin_ff};
         default:              prdata = '0;
      endcase
   end

   assign coeff_two_cos = two_cos_ff;
   assign cos_term      = cos_ff;
   assign sin_term      = sin_ff;

endmodule

`default_nettype wire

// ===== design/gtm_datapath.sv =====
// Datapath: delay accumulators, chunked shared multiplier, rounding,
// saturating add/subtract, digit-by-digit square root and the result register.
// Depends on gtm_pkg for the command type and constants.
`default_nettype none

module gtm_datapath #(
   parameter  int SAMPLE_WIDTH   = gtm_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter  int COEF_FRAC_BITS = gtm_pkg::COEF_FRAC_BITS_DEFAULT,
   parameter  int ACC_WIDTH      = gtm_pkg::ACC_WIDTH_DEFAULT,
   localparam int NCH   = (ACC_WIDTH + gtm_pkg::CHUNK_WIDTH - 1) / gtm_pkg::CHUNK_WIDTH,
   localparam int IDX_W = $clog2(NCH)
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire gtm_pkg::cmd_type                    cmd,
   input  wire logic [IDX_W-1:0]                    a_idx,
   input  wire logic [IDX_W-1:0]                    b_idx,
   input  wire logic [SAMPLE_WIDTH-1:0]             sample,
   input  wire logic [gtm_pkg::TWO_COS_WIDTH-1:0]   coeff_two_cos,
   input  wire logic [gtm_pkg::TRIG_WIDTH-1:0]      cos_term,
   input  wire logic [gtm_pkg::TRIG_WIDTH-1:0]      sin_term,
   output logic      [gtm_pkg::MAG_WIDTH-1:0]       magnitude
);

   localparam int CHW    = gtm_pkg::CHUNK_WIDTH;
   localparam int MW     = gtm_pkg::MAG_WIDTH;
   localparam int CW     = gtm_pkg::TWO_COS_WIDTH;
   localparam int TW     = gtm_pkg::TRIG_WIDTH;
   localparam int PAD_W  = NCH * CHW;
   localparam int PROD_W = 2 * PAD_W;
   localparam int RAD_W  = 2 * ACC_WIDTH;

   localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
   localparam logic [PROD_W:0]      HALF    = (PROD_W+1)'(1) << (COEF_FRAC_BITS - 1);

   // Clamp a sum one bit wider than the accumulators.
   function automatic logic [ACC_WIDTH-1:0] sat_acc(input logic [ACC_WIDTH:0] s);
      logic [ACC_WIDTH-1:0] r;
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         r = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         r = s[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

   logic [ACC_WIDTH-1:0] x_ff;
   logic [ACC_WIDTH-1:0] d1_ff;
   logic [ACC_WIDTH-1:0] d2_ff;
   logic [ACC_WIDTH-1:0] tmp_ff;
   logic [ACC_WIDTH-1:0] re_ff;
   logic                 neg_ff;
   logic [PROD_W-1:0]    acc_ff;
   logic [RAD_W-1:0]     rad_ff;
   logic [ACC_WIDTH+1:0] rem_ff;
   logic [ACC_WIDTH-1:0] root_ff;
   logic [MW-1:0]        mag_ff;

   logic [ACC_WIDTH-1:0] a_val;
   logic [ACC_WIDTH-1:0] a_mag;
   logic [PAD_W-1:0]     a_pad;
   logic [PAD_W-1:0]     b_pad;
   logic                 b_neg;
   logic [CW-1:0]        two_cos_mag;
   logic [TW-1:0]        cos_mag;
   logic [TW-1:0]        sin_mag;
   logic [ACC_WIDTH-1:0] re_mag;
   logic [ACC_WIDTH-1:0] im_mag;
   logic [CHW-1:0]       a_chunk;
   logic [CHW-1:0]       b_chunk;
   logic [2*CHW-1:0]     pp;
   logic [IDX_W:0]       sh_pos;
   logic [PROD_W-1:0]    pp_sh;
   logic [PROD_W-1:0]    acc_in;

   logic [PROD_W:0]      rnd_sum;
   logic [PROD_W:0]      rnd_shr;
   logic [PROD_W:0]      rnd_lim;
   logic [PROD_W:0]      rnd_sat;
   logic [ACC_WIDTH-1:0] rnd_val;

   logic [ACC_WIDTH-1:0] sub_d2;
   logic [ACC_WIDTH-1:0] add_x;
   logic [ACC_WIDTH-1:0] re_val;

   logic [ACC_WIDTH+1:0] rem_sh;
   logic [ACC_WIDTH+1:0] trial;
   logic                 take;
   logic [ACC_WIDTH+MW-1:0] root_wide;
   logic [MW-1:0]        mag_next;

   // Operand magnitudes.
   assign two_cos_mag = coeff_two_cos[CW-1] ? (CW)'(-coeff_two_cos) : coeff_two_cos;
   assign cos_mag     = cos_term[TW-1] ? (TW)'(-cos_term) : cos_term;
   assign sin_mag     = sin_term[TW-1] ? (TW)'(-sin_term) : sin_term;
   assign re_mag      = re_ff[ACC_WIDTH-1] ? (ACC_WIDTH)'(-re_ff) : re_ff;
   assign im_mag      = tmp_ff[ACC_WIDTH-1] ? (ACC_WIDTH)'(-tmp_ff) : tmp_ff;

   // Operand A select.
   always_comb begin
      case (cmd.a_sel)
         gtm_pkg::A_D1:   a_val = d1_ff;
         gtm_pkg::A_D2:   a_val = d2_ff;
         gtm_pkg::A_REAL: a_val = re_ff;
         gtm_pkg::A_IMAG: a_val = tmp_ff;
         default:         a_val = d1_ff;
      endcase
      a_mag = a_val[ACC_WIDTH-1] ? (ACC_WIDTH)'(-a_val) : a_val;
      a_pad = (PAD_W)'(a_mag);
   end

   // Operand B select, with its sign for the rounding step.
   always_comb begin
      case (cmd.b_sel)
         gtm_pkg::B_TWO_COS: begin
            b_pad = (PAD_W)'(two_cos_mag);
            b_neg = coeff_two_cos[CW-1];
         end
         gtm_pkg::B_COS: begin
            b_pad = (PAD_W)'(cos_mag);
            b_neg = cos_term[TW-1];
         end
         gtm_pkg::B_SIN: begin
            b_pad = (PAD_W)'(sin_mag);
            b_neg = sin_term[TW-1];
         end
         gtm_pkg::B_REAL: begin
            b_pad = (PAD_W)'(re_mag);
            b_neg = re_ff[ACC_WIDTH-1];
         end
         gtm_pkg::B_IMAG: begin
            b_pad = (PAD_W)'(im_mag);
            b_neg = tmp_ff[ACC_WIDTH-1];
         end
         default: begin
            b_pad = '0;
            b_neg = 1'b0;
         end
      endcase
   end

   // One chunk product per cycle, shifted into place and accumulated.
   assign a_chunk = a_pad[a_idx*CHW +: CHW];
   assign b_chunk = b_pad[b_idx*CHW +: CHW];
   assign pp      = a_chunk * b_chunk;
   assign sh_pos  = (IDX_W+1)'(a_idx) + (IDX_W+1)'(b_idx);
   assign pp_sh   = (PROD_W)'(pp) << (sh_pos * CHW);
   assign acc_in  = (cmd.acc_clr ? '0 : acc_ff) + pp_sh;

   // Scale the product magnitude, round half away from zero, saturate, apply sign.
   always_comb begin
      rnd_sum = (PROD_W+1)'(acc_ff) + HALF;
      rnd_shr = rnd_sum >> COEF_FRAC_BITS;
      rnd_lim = (PROD_W+1)'(ACC_MAX) + (PROD_W+1)'(neg_ff);
      rnd_sat = (rnd_shr > rnd_lim) ? rnd_lim : rnd_shr;
      rnd_val = neg_ff ? (ACC_WIDTH)'(-rnd_sat[ACC_WIDTH-1:0]) : rnd_sat[ACC_WIDTH-1:0];
   end

   // Saturating add and subtract steps.
   assign sub_d2 = sat_acc({tmp_ff[ACC_WIDTH-1], tmp_ff} - {d2_ff[ACC_WIDTH-1], d2_ff});
   assign add_x  = sat_acc({tmp_ff[ACC_WIDTH-1], tmp_ff} + {x_ff[ACC_WIDTH-1], x_ff});
   assign re_val = sat_acc({d1_ff[ACC_WIDTH-1], d1_ff} - {tmp_ff[ACC_WIDTH-1], tmp_ff});

   // One result bit of the square root per step.
   assign rem_sh = {rem_ff[ACC_WIDTH-1:0], rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};
   assign take   = (rem_sh >= trial);

   // Clamp the root to the magnitude width.
   always_comb begin
      root_wide = (ACC_WIDTH+MW)'(root_ff);
      if (root_wide > (ACC_WIDTH+MW)'({MW{1'b1}})) begin
         mag_next = '1;
      end else begin
         mag_next = root_wide[MW-1:0];
      end
   end

   // Delay accumulators: the recurrence state.
   always_ff @(posedge clock) begin
      if (reset) begin
         d1_ff <= '0;
         d2_ff <= '0;
      end else begin
         case (cmd.op)
            gtm_pkg::OP_ADD_X: begin
               d1_ff <= add_x;
               d2_ff <= d1_ff;
            end
            gtm_pkg::OP_ROOT_INIT: begin
               d1_ff <= '0;
               d2_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // Working registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         gtm_pkg::OP_LOAD: begin
            x_ff <= {{(ACC_WIDTH-SAMPLE_WIDTH){sample[SAMPLE_WIDTH-1]}}, sample};
         end
         gtm_pkg::OP_MUL: begin
            acc_ff <= acc_in;
            neg_ff <= a_val[ACC_WIDTH-1] ^ b_neg;
         end
         gtm_pkg::OP_ROUND: begin
            tmp_ff <= rnd_val;
         end
         gtm_pkg::OP_SUB_D2: begin
            tmp_ff <= sub_d2;
         end
         gtm_pkg::OP_REAL: begin
            re_ff <= re_val;
         end
         gtm_pkg::OP_ROOT_INIT: begin
            rad_ff  <= acc_ff[RAD_W-1:0];
            rem_ff  <= '0;
            root_ff <= '0;
         end
         gtm_pkg::OP_ROOT_STEP: begin
            rad_ff <= rad_ff << 2;
            if (take) begin
               rem_ff  <= rem_sh - trial;
               root_ff <= {root_ff[ACC_WIDTH-2:0], 1'b1};
            end else begin
               rem_ff  <= rem_sh;
               root_ff <= {root_ff[ACC_WIDTH-2:0], 1'b0};
            end
         end
         gtm_pkg::OP_OUT: begin
            mag_ff <= mag_next;
         end
         default: ;
      endcase
   end

   assign magnitude = mag_ff;

endmodule

`default_nettype wire

// ===== design/gtm_ctrl.sv =====
// Controller: sequences the recurrence per sample and the magnitude
// computation on the last sample; owns both channel handshakes.
// Depends on gtm_pkg for the command type.
`default_nettype none

module gtm_ctrl #(
   parameter  int ACC_WIDTH = gtm_pkg::ACC_WIDTH_DEFAULT,
   localparam int NCH   = (ACC_WIDTH + gtm_pkg::CHUNK_WIDTH - 1) / gtm_pkg::CHUNK_WIDTH,
   localparam int IDX_W = $clog2(NCH)
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   input  wire logic             req_last,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output gtm_pkg::cmd_type      cmd,
   output logic [IDX_W-1:0]      a_idx,
   output logic [IDX_W-1:0]      b_idx
);

   localparam int CNT_W = $clog2(ACC_WIDTH);
   localparam logic [IDX_W-1:0] IDX_LAST = (IDX_W)'(NCH - 1);
   localparam logic [CNT_W-1:0] CNT_INIT = (CNT_W)'(ACC_WIDTH - 1);
   localparam int SAMPLE_CYCLES = NCH + 4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_ROUND,
      ST_SUB,
      ST_ADD,
      ST_CMUL,
      ST_CRND,
      ST_REAL,
      ST_SMUL,
      ST_SRND,
      ST_SQ_RE,
      ST_SQ_IM,
      ST_ROOT_INIT,
      ST_ROOT,
      ST_OUT
   } state_type;

   state_type        state_ff;
   logic [IDX_W-1:0] ai_ff;
   logic [IDX_W-1:0] bi_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             last_ff;
   logic             rsp_valid_ff;
   logic             out_free;
   logic             a_end;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign a_end     = (ai_ff == IDX_LAST);
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign a_idx     = ai_ff;
   assign b_idx     = bi_ff;

   // Command decode from the current state.
   always_comb begin
      cmd.op      = gtm_pkg::OP_IDLE;
      cmd.a_sel   = gtm_pkg::A_D1;
      cmd.b_sel   = gtm_pkg::B_TWO_COS;
      cmd.acc_clr = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.op = gtm_pkg::OP_LOAD;
            end
         end
         ST_MUL: begin
            cmd.op      = gtm_pkg::OP_MUL;
            cmd.acc_clr = (ai_ff == '0);
         end
         ST_CMUL: begin
            cmd.op      = gtm_pkg::OP_MUL;
            cmd.a_sel   = gtm_pkg::A_D2;
            cmd.b_sel   = gtm_pkg::B_COS;
            cmd.acc_clr = (ai_ff == '0);
         end
         ST_SMUL: begin
            cmd.op      = gtm_pkg::OP_MUL;
            cmd.a_sel   = gtm_pkg::A_D2;
            cmd.b_sel   = gtm_pkg::B_SIN;
            cmd.acc_clr = (ai_ff == '0);
         end
         ST_SQ_RE: begin
            cmd.op      = gtm_pkg::OP_MUL;
            cmd.a_sel   = gtm_pkg::A_REAL;
            cmd.b_sel   = gtm_pkg::B_REAL;
            cmd.acc_clr = (ai_ff == '0) && (bi_ff == '0);
         end
         ST_SQ_IM: begin
            cmd.op    = gtm_pkg::OP_MUL;
            cmd.a_sel = gtm_pkg::A_IMAG;
            cmd.b_sel = gtm_pkg::B_IMAG;
         end
         ST_ROUND, ST_CRND, ST_SRND: cmd.op = gtm_pkg::OP_ROUND;
         ST_SUB:       cmd.op = gtm_pkg::OP_SUB_D2;
         ST_ADD:       cmd.op = gtm_pkg::OP_ADD_X;
         ST_REAL:      cmd.op = gtm_pkg::OP_REAL;
         ST_ROOT_INIT: cmd.op = gtm_pkg::OP_ROOT_INIT;
         ST_ROOT:      cmd.op = gtm_pkg::OP_ROOT_STEP;
         ST_OUT: begin
            if (out_free) begin
               cmd.op = gtm_pkg::OP_OUT;
            end
         end
         default: ;
      endcase
   end

   // State, chunk indexes, root counter and the result valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ai_ff        <= '0;
         bi_ff        <= '0;
         cnt_ff       <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output state sets the flag itself when it hands over a result.
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  last_ff  <= req_last;
                  ai_ff    <= '0;
                  bi_ff    <= '0;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL, ST_CMUL, ST_SMUL: begin
               if (a_end) begin
                  ai_ff <= '0;
                  case (state_ff)
                     ST_MUL:  state_ff <= ST_ROUND;
                     ST_CMUL: state_ff <= ST_CRND;
                     default: state_ff <= ST_SRND;
                  endcase
               end else begin
                  ai_ff <= ai_ff + 1'b1;
               end
            end
            ST_ROUND: state_ff <= ST_SUB;
            ST_SUB:   state_ff <= ST_ADD;
            ST_ADD:   state_ff <= last_ff ? ST_CMUL : ST_IDLE;
            ST_CRND:  state_ff <= ST_REAL;
            ST_REAL:  state_ff <= ST_SMUL;
            ST_SRND:  state_ff <= ST_SQ_RE;
            ST_SQ_RE, ST_SQ_IM: begin
               if (bi_ff == IDX_LAST) begin
                  bi_ff <= '0;
                  if (a_end) begin
                     ai_ff    <= '0;
                     state_ff <= (state_ff == ST_SQ_RE) ? ST_SQ_IM : ST_ROOT_INIT;
                  end else begin
                     ai_ff <= ai_ff + 1'b1;
                  end
               end else begin
                  bi_ff <= bi_ff + 1'b1;
               end
            end
            ST_ROOT_INIT: begin
               cnt_ff   <= CNT_INIT;
               state_ff <= ST_ROOT;
            end
            ST_ROOT: begin
               if (cnt_ff == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_OUT: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

`ifndef SYNTH
   // A sample that does not close a block passes through the multiply, round, subtract and add states back to idle.
   a_sample_time: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && req_valid && !req_last) |-> ##SAMPLE_CYCLES (state_ff == ST_IDLE))
      else $error("non-last sample did not return to idle on time");

   // A pending result is never overwritten.
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT && rsp_valid_ff && rsp_stall) |=> (state_ff == ST_OUT))
      else $error("result stage left while the previous result was stalled");

   // A result appears only from the output state.
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("result valid raised outside the output state");

   // The square root runs exactly one step per result bit.
   a_root_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROOT_INIT) |=> (state_ff == ST_ROOT && cnt_ff == CNT_INIT))
      else $error("square root counter not loaded");
`endif

endmodule

`default_nettype wire

// ===== design/goertzel_tone_magnitude_top.sv =====
// Top level of the single-bin Goertzel tone magnitude detector.
// Instantiates gtm_csr, gtm_ctrl and gtm_datapath; uses gtm_pkg.
//
//   Channel  Direction  Handshake                 Payload
//   req      in         req_valid / req_stall     req_sample, req_last
//   rsp      out        rsp_valid / rsp_stall     rsp_magnitude
//   csr      in/out     psel, penable, pready     paddr, pwrite, pwdata, prdata
//
// One sample at a time; NCH = ceil(ACC_WIDTH/24) is the chunk count of the
// 24x24 chunk multiplier. A last sample also runs the cos and sin products,
// the squares of both parts and the one-bit-per-cycle square root. Reset is
// synchronous; it clears the delay accumulators and the control state and sets
// the configuration registers to their defaults.
// A finished result waits in its output register while new samples are taken;
// the next result and the sample input stall until the waiting one is taken.
`default_nettype none

module goertzel_tone_magnitude_top #(
   parameter int SAMPLE_WIDTH   = gtm_pkg::SAMPLE_WIDTH_DEFAULT,
   parameter int COEF_FRAC_BITS = gtm_pkg::COEF_FRAC_BITS_DEFAULT,
   parameter int ACC_WIDTH      = gtm_pkg::ACC_WIDTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [SAMPLE_WIDTH-1:0]             req_sample,
   input  wire logic                                req_last,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [gtm_pkg::MAG_WIDTH-1:0]       rsp_magnitude,
   input  wire logic                                psel,
   input  wire logic                                penable,
   input  wire logic                                pwrite,
   input  wire logic [gtm_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [gtm_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [gtm_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                     pready
);

   localparam int NCH   = (ACC_WIDTH + gtm_pkg::CHUNK_WIDTH - 1) / gtm_pkg::CHUNK_WIDTH;
   localparam int IDX_W = $clog2(NCH);

   logic [gtm_pkg::TWO_COS_WIDTH-1:0] coeff_two_cos;
   logic [gtm_pkg::TRIG_WIDTH-1:0]    cos_term;
   logic [gtm_pkg::TRIG_WIDTH-1:0]    sin_term;
   gtm_pkg::cmd_type                  cmd;
   logic [IDX_W-1:0]                  a_idx;
   logic [IDX_W-1:0]                  b_idx;

   // Configuration registers.
   gtm_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready),
      .coeff_two_cos (coeff_two_cos),
      .cos_term      (cos_term),
      .sin_term      (sin_term)
   );

   // Sequencer.
   gtm_ctrl #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_last),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .a_idx     (a_idx),
      .b_idx     (b_idx)
   );

   // Arithmetic.
   gtm_datapath #(
      .SAMPLE_WIDTH   (SAMPLE_WIDTH),
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .ACC_WIDTH      (ACC_WIDTH)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .a_idx         (a_idx),
      .b_idx         (b_idx),
      .sample        (req_sample),
      .coeff_two_cos (coeff_two_cos),
      .cos_term      (cos_term),
      .sin_term      (sin_term),
      .magnitude     (rsp_magnitude)
   );

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the single-bin Goertzel tone magnitude detector.
// Depends on gtm_pkg and goertzel_tone_magnitude_top; predicts each bin magnitude
// in bit-exact fixed point and compares it with every result transfer.
`timescale 1ns / 100ps

module tb_top;

   // Predictor arithmetic: accumulators at the block's width, a wide type for
   // intermediate sums and products so that saturation can be applied exactly.
   localparam int FRAC_BITS = gtm_pkg::COEF_FRAC_BITS_DEFAULT;
   localparam int SW        = gtm_pkg::SAMPLE_WIDTH_DEFAULT;
   localparam int MW        = gtm_pkg::MAG_WIDTH;
   localparam int DW        = gtm_pkg::CSR_DATA_WIDTH;
   localparam int CW        = gtm_pkg::TWO_COS_WIDTH;
   localparam int TW        = gtm_pkg::TRIG_WIDTH;
   typedef logic signed [gtm_pkg::ACC_WIDTH_DEFAULT-1:0] acc_type;
   typedef logic signed [127:0]                          wide_type;
   localparam wide_type ACC_HI = 128'sh7FFF_FFFF_FFFF;
   localparam wide_type ACC_LO = -128'sh8000_0000_0000;
   localparam wide_type ROUND_HALF = wide_type'(1) <<< (FRAC_BITS - 1);
   localparam logic [63:0] MAG_LIMIT = (64'd1 << MW) - 1;

   // An index with no register behind it; writes there must change nothing.
   localparam logic [1:0] REG_UNUSED = 2'd3;

   localparam int SETTLE_CYCLES = 150;
   localparam int HOLD_CYCLES   = 800;
   localparam int SOAK_LENGTH   = 120;
   localparam int PHASE_ITEMS   = 115;

   typedef struct {
      logic [SW-1:0] sample;
      logic          last;
   } sample_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [SW-1:0] req_sample = '0;
   logic req_last = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [MW-1:0] rsp_magnitude;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [gtm_pkg::CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [DW-1:0] pwdata = '0;
   logic [DW-1:0] prdata;
   logic pready;

   // Predictor state and its copy of the coefficient registers.
   logic signed [CW-1:0] two_cos_q14 = '0;
   logic signed [TW-1:0] cos_q14 = 16'sd16384;
   logic signed [TW-1:0] sin_q14 = '0;
   acc_type acc_one = '0;
   acc_type acc_two = '0;

   sample_item_type pending_samples[$];
   logic [MW-1:0]   bin_magnitudes[$];
   sample_item_type next_item;
   logic [MW-1:0]   want_magnitude;
   int  mismatch_count = 0;
   int  hold_left = 0;
   bit  hold_arm = 1'b0;
   bit  hold_used = 1'b0;
   bit  calm = 1'b0;

   goertzel_tone_magnitude_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_sample    (req_sample),
      .req_last      (req_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_magnitude (rsp_magnitude),
      .psel          (psel),
      .penable       (penable),
      .pwrite        (pwrite),
      .paddr         (paddr),
      .pwdata        (pwdata),
      .prdata        (prdata),
      .pready        (pready)
   );

   always #4 clock = ~clock;

   // Saturate a wide value to the signed accumulator range.
   function automatic acc_type clamp_acc(input wide_type v);
      if (v > ACC_HI) return acc_type'(ACC_HI);
      if (v < ACC_LO) return acc_type'(ACC_LO);
      return acc_type'(v);
   endfunction

   // Q14 product, rounded half away from zero and saturated. The negative
   // limit is one larger in magnitude than the positive one.
   function automatic acc_type scaled_product(input acc_type a, input wide_type c);
      wide_type wa, mag, lim;
      logic     neg;
      wa = a;
      neg = (wa < 0) != (c < 0);
      mag = (wa < 0 ? -wa : wa) * (c < 0 ? -c : c);
      mag = (mag + ROUND_HALF) >>> FRAC_BITS;
      lim = ACC_HI + (neg ? 1 : 0);
      if (mag > lim) mag = lim;
      return acc_type'(neg ? -mag : mag);
   endfunction

   // Floor of the square root of a 128-bit value, one bit at a time.
   function automatic logic [63:0] root_floor(input logic [127:0] v);
      logic [63:0] r, c;
      r = '0;
      for (int b = 63; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   // One recurrence step; a last sample also yields the bin magnitude and
   // clears the delays for the next block.
   function automatic void goertzel_step(input logic signed [SW-1:0] x,
                                         input logic last);
      acc_type     q0, re, im;
      wide_type    sum;
      logic [63:0] mag;
      q0 = scaled_product(acc_one, two_cos_q14);
      q0 = clamp_acc(wide_type'(q0) - wide_type'(acc_two));
      q0 = clamp_acc(wide_type'(q0) + wide_type'(x));
      acc_two = acc_one;
      acc_one = q0;
      if (last) begin
         re = clamp_acc(wide_type'(acc_one) - wide_type'(scaled_product(acc_two, cos_q14)));
         im = scaled_product(acc_two, sin_q14);
         sum = wide_type'(re) * wide_type'(re) + wide_type'(im) * wide_type'(im);
         mag = root_floor(sum);
         if (mag > MAG_LIMIT) mag = MAG_LIMIT;
         bin_magnitudes.push_back(mag[MW-1:0]);
         acc_one = '0;
         acc_two = '0;
      end
   endfunction

   // Sample driver: predicts on each accepted transfer, then offers the next
   // queued sample unless it idles this cycle.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_sample <= '0;
         req_last <= 1'b0;
         acc_one <= '0;
         acc_two <= '0;
      end else begin
         if (req_valid && !req_stall) goertzel_step(req_sample, req_last);
         if (!req_valid || !req_stall) begin
            if (pending_samples.size() != 0 && (calm || $urandom_range(99) >= 9)) begin
               next_item = pending_samples.pop_front();
               req_valid <= 1'b1;
               req_sample <= next_item.sample;
               req_last <= next_item.last;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: random stalls, plus one long hold-off so the block
   // backs up and stalls its sample input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
         hold_used <= 1'b0;
      end else if (hold_arm && !hold_used) begin
         hold_used <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= calm ? 1'b0 : ($urandom_range(99) < 9);
      end
   end

   // Result monitor: every transfer must match the oldest predicted magnitude.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (bin_magnitudes.size() == 0) begin
            $error("magnitude: unexpected result, got %0d", rsp_magnitude);
            mismatch_count++;
         end else begin
            want_magnitude = bin_magnitudes.pop_front();
            if (rsp_magnitude !== want_magnitude) begin
               $error("magnitude: expected %0d, got %0d", want_magnitude, rsp_magnitude);
               mismatch_count++;
            end
         end
      end
   end

   // Register write: setup phase, then access phase until pready.
   task automatic write_reg(input logic [1:0] index, input logic [DW-1:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {index, 2'b00};
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (index)
         gtm_pkg::REG_TWO_COS: two_cos_q14 = data[CW-1:0];
         gtm_pkg::REG_COS:     cos_q14 = data[TW-1:0];
         gtm_pkg::REG_SIN:     sin_q14 = data[TW-1:0];
         default: ;
      endcase
   endtask

   // Load all three coefficients; upper bits carry random junk.
   task automatic program_bin(input int two_cos, input int cos_v, input int sin_v);
      logic [DW-1:0] word;
      word = $urandom;
      word[CW-1:0] = two_cos[CW-1:0];
      write_reg(gtm_pkg::REG_TWO_COS, word);
      word = $urandom;
      word[TW-1:0] = cos_v[TW-1:0];
      write_reg(gtm_pkg::REG_COS, word);
      word = $urandom;
      word[TW-1:0] = sin_v[TW-1:0];
      write_reg(gtm_pkg::REG_SIN, word);
   endtask

   task automatic program_random_bin();
      program_bin(int'($urandom_range(65536)) - 32768, int'($urandom_range(32768)) - 16384,
                  int'($urandom_range(32768)) - 16384);
   endtask

   task automatic push_sample(input logic [SW-1:0] s, input logic last);
      sample_item_type item;
      item.sample = s;
      item.last = last;
      pending_samples.push_back(item);
   endtask

   // Random analysis blocks: mostly short, some medium, a few long.
   task automatic queue_random_blocks(input int budget);
      int queued, span, pick;
      logic [SW-1:0] s;
      queued = 0;
      while (queued < budget) begin
         pick = $urandom_range(99);
         if (pick < 80) span = $urandom_range(8, 1);
         else if (pick < 95) span = $urandom_range(30, 9);
         else span = $urandom_range(90, 40);
         for (int k = 0; k < span; k++) begin
            pick = $urandom_range(9);
            if (pick < 6) begin
               s = 16'($urandom);
            end else if (pick < 8) begin
               s = 16'($urandom_range(255));
               if ($urandom_range(1)) s = -s;
            end else begin
               s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            push_sample(s, k == span - 1);
            queued++;
         end
      end
   endtask

   // Wait until every sample is taken and every magnitude has come back,
   // then let the block finish any step still in flight.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_samples.size() != 0 || req_valid || bin_magnitudes.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Test sequence.
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Reset coefficients: no feedback, real part only.
      push_sample(16'h1234, 1'b0);
      push_sample(16'h7FFF, 1'b1);
      push_sample(16'h8000, 1'b1);
      wait_drained();

      // Directed: a realistic tone bin, an ignored write, sample extremes.
      program_bin(27246, 13623, 9102);
      write_reg(REG_UNUSED, $urandom);
      push_sample(16'h7FFF, 1'b1);
      push_sample(16'h8000, 1'b1);
      push_sample(16'h0000, 1'b1);
      push_sample(16'h7FFF, 1'b0);
      push_sample(16'h8000, 1'b0);
      push_sample(16'h0001, 1'b0);
      push_sample(16'hFFFF, 1'b0);
      push_sample(16'h5555, 1'b0);
      push_sample(16'hAAAA, 1'b1);
      push_sample(16'h0001, 1'b0);
      push_sample(16'hFFFF, 1'b0);
      push_sample(16'h0002, 1'b0);
      push_sample(16'hFFFE, 1'b1);
      for (int k = 0; k < 6; k++) push_sample(16'h7FFF, k == 5);
      wait_drained();

      // A feedback coefficient of minus four makes the recurrence unstable, so
      // full-scale alternating input drives the accumulators, products, real
      // and imaginary parts into saturation within a few samples.
      program_bin(-65536, 16384, 16384);
      calm = 1'b1;
      for (int n = 0; n < SOAK_LENGTH; n++)
         push_sample(n % 2 == 0 ? 16'h7FFF : 16'h8000,
                     n % 23 == 22 || n == SOAK_LENGTH - 1);
      wait_drained();
      calm = 1'b0;

      // Random blocks over several coefficient settings, extremes first.
      program_bin(32768, 16384, -16384);
      queue_random_blocks(PHASE_ITEMS);
      wait_drained();

      program_random_bin();
      hold_arm = 1'b1;
      queue_random_blocks(PHASE_ITEMS);
      wait_drained();

      program_bin(0, -16384, 16384);
      calm = 1'b1;
      queue_random_blocks(PHASE_ITEMS);
      wait_drained();
      calm = 1'b0;

      program_random_bin();
      queue_random_blocks(PHASE_ITEMS);
      wait_drained();

      if (mismatch_count == 0 && bin_magnitudes.size() == 0) begin
         $display("goertzel_tone_magnitude_top test passed");
      end else begin
         $display("goertzel_tone_magnitude_top test failed");
      end
      $finish;
   end

   // Watchdog for a hung handshake.
   initial begin
      #2_000_000;
      $display("goertzel_tone_magnitude_top test failed");
      $finish;
   end

endmodule
